### hdl/rpg_pkg.sv
// Shared package for the Reed-Solomon parity generator.
// Holds the GF(256) constants and the field multiply used by the LFSR and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpg_pkg;

  // Field reduction polynomial x^8 + x^4 + x^3 + x^2 + 1.
  localparam logic [8:0] GF_POLY = 9'h11D;

  // Primitive element of the field.
  localparam logic [7:0] GF_ALPHA = 8'h02;

  // Parity count after reset.
  localparam logic [4:0] PARITY_COUNT_RESET = 5'd10;

  // Number of finished parity blocks that can wait between front and back.
  localparam int QUEUE_DEPTH = 2;

  // GF(256) multiply: shift-and-add with reduction, eight narrow steps.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x   = {1'b0, a};
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

### hdl/rpg_if.sv
// Channel interfaces of the parity generator: data input, parity output and
// the configuration write channel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

// Data bytes of one block, one per transfer.
interface rpg_data_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_data;

  modport source (output valid, output data_byte, output last_data, input ready);
  modport sink (input valid, input data_byte, input last_data, output ready);
endinterface

// Parity bytes, highest-order remainder byte first.
interface rpg_parity_if;
  logic       valid;
  logic       ready;
  logic [7:0] parity_byte;
  logic       last_parity;

  modport source (output valid, output parity_byte, output last_parity, input ready);
  modport sink (input valid, input parity_byte, input last_parity, output ready);
endinterface

// Configuration write of the parity count.
interface rpg_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] parity_count;

  modport source (output valid, output parity_count, input ready);
  modport sink (input valid, input parity_count, output ready);
endinterface

`default_nettype wire

### hdl/rpg_lfsr.sv
// Front end: byte-wide LFSR that folds data bytes into the parity remainder
// and hands the finished remainder to the block queue. Uses rpg_pkg, rpg_if.
`timescale 1ns / 1ps
`default_nettype none

module rpg_lfsr
  import rpg_pkg::*;
#(
  parameter int MAX_PARITY = 30,
  parameter int NW = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  rpg_data_if.sink                        data,
  input  logic [NW-1:0]                   n_eff,
  input  logic [MAX_PARITY-1:0][7:0]      gen,
  output logic                            push_valid,
  input  logic                            push_ready,
  output logic [MAX_PARITY-1:0][7:0]      push_bytes,
  output logic [NW-1:0]                   push_n
);

  logic [MAX_PARITY-1:0][7:0] rem;
  logic [MAX_PARITY-1:0][7:0] rem_next;
  logic [MAX_PARITY-1:0][7:0] rem_up;
  logic [7:0]                 fb;
  logic                       xfer;

  // A byte is taken only when the queue has room for a finished block.
  assign data.ready = push_ready;
  assign xfer       = data.valid && push_ready;

  // Feedback times each generator coefficient, added to the shifted remainder.
  // Entries above the current degree are held unchanged.
  always_comb begin
    fb     = data.data_byte ^ rem[0];
    rem_up = rem >> 8;
    for (int j = 0; j < MAX_PARITY; j++) begin
      if (j < int'(n_eff)) begin
        if (j + 1 < int'(n_eff)) begin
          rem_next[j] = rem_up[j] ^ gf_mul(fb, gen[j]);
        end else begin
          rem_next[j] = gf_mul(fb, gen[j]);
        end
      end else begin
        rem_next[j] = rem[j];
      end
    end
  end

  // The last byte of a block pushes the final remainder into the queue.
  assign push_valid = xfer && data.last_data;
  assign push_bytes = rem_next;
  assign push_n     = n_eff;

  // Remainder register, cleared at the end of every block.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (xfer) begin
      if (data.last_data) begin
        rem <= '0;
      end else begin
        rem <= rem_next;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/rpg_block_queue.sv
// Short queue of finished parity blocks between the LFSR and the serializer.
// Uses rpg_pkg for the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module rpg_block_queue
  import rpg_pkg::*;
#(
  parameter int MAX_PARITY = 30,
  parameter int NW = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push_valid,
  output logic                       push_ready,
  input  logic [MAX_PARITY-1:0][7:0] push_bytes,
  input  logic [NW-1:0]              push_n,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output logic [MAX_PARITY-1:0][7:0] pop_bytes,
  output logic [NW-1:0]              pop_n
);

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [MAX_PARITY-1:0][7:0] bytes_q [QUEUE_DEPTH];
  logic [NW-1:0]              n_q     [QUEUE_DEPTH];
  logic [QPW-1:0]             wr_ptr;
  logic [QPW-1:0]             rd_ptr;
  logic [QCW-1:0]             count;
  logic                       do_push;
  logic                       do_pop;

  assign push_ready = (count != QCW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_bytes  = bytes_q[rd_ptr];
  assign pop_n      = n_q[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      bytes_q[wr_ptr] <= push_bytes;
      n_q[wr_ptr]     <= push_n;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/rpg_serializer.sv
// Back end: takes one finished block from the queue and sends its parity
// bytes one per transfer, marking the final one. Uses rpg_pkg, rpg_if.
`timescale 1ns / 1ps
`default_nettype none

module rpg_serializer
  import rpg_pkg::*;
#(
  parameter int MAX_PARITY = 30,
  parameter int NW = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  logic [MAX_PARITY-1:0][7:0] pop_bytes,
  input  logic [NW-1:0]              pop_n,
  rpg_parity_if.source               parity
);

  logic                       busy;
  logic [NW-1:0]              cnt;
  logic [MAX_PARITY-1:0][7:0] sh;
  logic                       final_byte;
  logic                       load;

  assign final_byte = (cnt == NW'(1));

  // A new block loads when idle or as the final byte of the current one leaves.
  assign pop_ready = !busy || (parity.ready && final_byte);
  assign load      = pop_valid && pop_ready;

  assign parity.valid       = busy;
  assign parity.parity_byte = sh[0];
  assign parity.last_parity = final_byte;

  // Control: busy flag and count of bytes still to send.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= pop_n;
    end else if (busy && parity.ready) begin
      if (final_byte) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Shift register of the block's parity bytes.
  always_ff @(posedge clk) begin
    if (load) begin
      sh <= pop_bytes;
    end else if (busy && parity.ready) begin
      sh <= sh >> 8;
    end
  end

endmodule

`default_nettype wire

### hdl/rs_parity_generator_core.sv
// Top level of the Reed-Solomon parity generator: configuration register,
// generator table and the front/queue/back datapath. Uses rpg_pkg, rpg_if.
//
//  Channel  | Role   | Payload                     | Transfer
//  ---------+--------+-----------------------------+--------------------------
//  data     | sink   | data_byte[7:0], last_data   | valid & ready
//  parity   | source | parity_byte[7:0], last_parity| valid & ready
//  cfg      | sink   | parity_count[4:0]           | valid & ready (ready = 1)
//
// One data byte is taken every cycle; the LFSR update is parallel GF(256)
// multiplies. A block's n parity bytes leave at one per cycle from the
// serializer while parity.ready holds, so the output port sets the sustained
// block rate. Data input stalls only when the two-entry block queue is full.
// Reset is synchronous; after reset the parity count is 10, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rs_parity_generator_core
  import rpg_pkg::*;
#(
  parameter int MAX_PARITY = 30
) (
  input  logic         clk,
  input  logic         rst,
  rpg_data_if.sink     data,
  rpg_parity_if.source parity,
  rpg_cfg_if.sink      cfg
);

  localparam int NW = $clog2(MAX_PARITY + 1);
  localparam int IW = $clog2(MAX_PARITY);

  typedef logic [MAX_PARITY-1:0][7:0] coef_vec_t;

  // Generator coefficients for every degree, built at elaboration.
  function automatic logic [MAX_PARITY-1:0][MAX_PARITY-1:0][7:0] build_gen_table();
    logic [MAX_PARITY-1:0][MAX_PARITY-1:0][7:0] t;
    logic [MAX_PARITY:0][7:0]                   p;
    logic [7:0]                                 root;
    t = '0;
    for (int n = 1; n <= MAX_PARITY; n++) begin
      p    = '0;
      p[0] = 8'h01;
      root = 8'h01;
      for (int i = 0; i < n; i++) begin
        for (int k = i + 1; k >= 1; k--) begin
          p[k] = p[k-1] ^ gf_mul(p[k], root);
        end
        p[0] = gf_mul(p[0], root);
        root = gf_mul(root, GF_ALPHA);
      end
      for (int k = 0; k < n; k++) begin
        t[n-1][k] = p[n-1-k];
      end
    end
    return t;
  endfunction

  // Clamp a written parity count into the supported degree range.
  function automatic logic [NW-1:0] clamp_n(input logic [4:0] pc);
    int v;
    v = int'(pc);
    if (v < 1) begin
      v = 1;
    end
    if (v > MAX_PARITY) begin
      v = MAX_PARITY;
    end
    return NW'(v);
  endfunction

  localparam logic [MAX_PARITY-1:0][MAX_PARITY-1:0][7:0] GEN_TABLE = build_gen_table();
  localparam int RESET_N = (int'(PARITY_COUNT_RESET) > MAX_PARITY) ?
                           MAX_PARITY : int'(PARITY_COUNT_RESET);

  logic [NW-1:0]              n_eff;
  coef_vec_t                  gen;
  logic [NW-1:0]              cfg_n;
  logic [NW-1:0]              cfg_nm1;
  logic [IW-1:0]              cfg_idx;

  logic                       q_push_valid;
  logic                       q_push_ready;
  coef_vec_t                  q_push_bytes;
  logic [NW-1:0]              q_push_n;
  logic                       q_pop_valid;
  logic                       q_pop_ready;
  coef_vec_t                  q_pop_bytes;
  logic [NW-1:0]              q_pop_n;

  // Configuration: clamp the count and look up its generator.
  assign cfg.ready = 1'b1;
  assign cfg_n     = clamp_n(cfg.parity_count);
  assign cfg_nm1   = cfg_n - NW'(1);
  assign cfg_idx   = cfg_nm1[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      n_eff <= NW'(RESET_N);
      gen   <= GEN_TABLE[RESET_N-1];
    end else if (cfg.valid && cfg.ready) begin
      n_eff <= cfg_n;
      gen   <= GEN_TABLE[cfg_idx];
    end
  end

  // Front end: remainder LFSR.
  rpg_lfsr #(
    .MAX_PARITY (MAX_PARITY),
    .NW         (NW)
  ) u_lfsr (
    .clk        (clk),
    .rst        (rst),
    .data       (data),
    .n_eff      (n_eff),
    .gen        (gen),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_bytes (q_push_bytes),
    .push_n     (q_push_n)
  );

  // Queue of finished blocks.
  rpg_block_queue #(
    .MAX_PARITY (MAX_PARITY),
    .NW         (NW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_bytes (q_push_bytes),
    .push_n     (q_push_n),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_bytes  (q_pop_bytes),
    .pop_n      (q_pop_n)
  );

  // Back end: parity byte serializer.
  rpg_serializer #(
    .MAX_PARITY (MAX_PARITY),
    .NW         (NW)
  ) u_serializer (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_bytes (q_pop_bytes),
    .pop_n     (q_pop_n),
    .parity    (parity)
  );

`ifndef SYNTHESIS
  // A finished block is never offered to a full queue.
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    q_push_valid |-> q_push_ready)
    else $error("block pushed into full queue");

  // Within a block the parity stream has no gaps.
  a_block_contiguous: assert property (@(posedge clk) disable iff (rst)
    (parity.valid && parity.ready && !parity.last_parity) |=> parity.valid)
    else $error("parity stream broke before the final byte");

  // The last data byte leads to parity output through the queue and serializer.
  a_last_gives_parity: assert property (@(posedge clk) disable iff (rst)
    (data.valid && data.ready && data.last_data) |=> ##1 parity.valid)
    else $error("no parity output after the last data byte");

  // The effective degree stays inside the supported range.
  a_degree_range: assert property (@(posedge clk) disable iff (rst)
    (n_eff != '0) && (int'(n_eff) <= MAX_PARITY))
    else $error("effective parity count out of range");
`endif

endmodule

`default_nettype wire
